// ----- rtl/qsms_pkg.sv -----
// ----------------------------------------------------------------------------
// qsms_pkg: shared types and constants of the servo move sequencer
// Command codes, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package qsms_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    localparam int unsigned POS_W     = 9;
    localparam int unsigned MOVE_W    = POS_W + 1;  // kind bit above the target
    localparam int unsigned CMD_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK        = 4'd0;
    localparam logic [CMD_W-1:0] CMD_QUEUE_LIFT  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_QUEUE_CLAMP = 4'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD        = 4'd3;
    localparam logic [CMD_W-1:0] CMD_UNLOAD      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_STACK       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PAUSE       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_UNPAUSE     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CLEAR       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_HOME        = 4'd9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_DOWN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_UP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_OPEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_CLOSE = 2'd3;

    localparam logic [POS_W-1:0] RST_LIFT_DOWN   = 9'd0;
    localparam logic [POS_W-1:0] RST_LIFT_UP     = 9'd180;
    localparam logic [POS_W-1:0] RST_CLAMP_OPEN  = 9'd180;
    localparam logic [POS_W-1:0] RST_CLAMP_CLOSE = 9'd90;

    localparam logic [POS_W-1:0] MIRROR_SUM = 9'd300;

    localparam logic KIND_LIFT  = 1'b0;
    localparam logic KIND_CLAMP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIFT,
        ST_CLAMP,
        ST_PUSH,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/qsms_ram.sv -----
// ----------------------------------------------------------------------------
// qsms_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qsms_ram #(
    parameter int unsigned P_WIDTH = qsms_pkg::MOVE_W,
    parameter int unsigned P_DEPTH = qsms_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  wire logic [P_WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic      [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/queued_servo_move_sequencer.sv -----
// ----------------------------------------------------------------------------
// queued_servo_move_sequencer: queued lift / clamp servo move sequencer
// Move queue held in a RAM; a small sequencer queues moves and steps the
// servo positions on ticks, one result per command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_ready     | i_command, i_target
//  out     | source    | o_out_valid / i_out_ready   | o_lift_position, o_clamp_position,
//          |           |                             | o_clamp_mirror_position,
//          |           |                             | o_busy_res, o_dropped
//  cfg     | sink      | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One command at a time. Tick: IDLE, LIFT, optional CLAMP, RESULT (one RAM read
//  for the head move, a second when a finished lift move leaves more moves queued);
//  a paused tick or one on an empty queue goes straight to RESULT. Queue, load,
//  unload, stack: one PUSH step per move queued (one RAM write port). Pause,
//  unpause, clear, home: straight to RESULT. The output register lets a new
//  command in while a result waits; a stalled output holds the next result back
//  in RESULT. Reset is synchronous; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module queued_servo_move_sequencer #(
    parameter int unsigned QUEUE_DEPTH = qsms_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [qsms_pkg::CMD_W-1:0]     i_command,
    input  wire logic [qsms_pkg::POS_W-1:0]     i_target,

    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [qsms_pkg::POS_W-1:0]     o_lift_position,
    output logic      [qsms_pkg::POS_W-1:0]     o_clamp_position,
    output logic      [qsms_pkg::POS_W-1:0]     o_clamp_mirror_position,
    output logic                                o_busy_res,
    output logic                                o_dropped,

    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [qsms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [qsms_pkg::POS_W-1:0]     i_cfg_data
);

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PW = qsms_pkg::POS_W;

    qsms_pkg::t_state r_state, n_state;

    logic [qsms_pkg::CMD_W-1:0] r_cmd,    n_cmd;
    logic [PW-1:0]              r_target, n_target;
    logic [1:0]                 r_step,   n_step;
    logic [AW-1:0]              r_head,   n_head;
    logic [CW-1:0]              r_count,  n_count;
    logic [PW-1:0]              r_lift,   n_lift;
    logic [PW-1:0]              r_clamp,  n_clamp;
    logic                       r_paused, n_paused;
    logic                       r_drop,   n_drop;

    logic [PW-1:0] r_lift_down, r_lift_up, r_clamp_open, r_clamp_close;

    logic          r_out_valid;
    logic [PW-1:0] r_out_lift, r_out_clamp, r_out_mirror;
    logic          r_out_busy, r_out_drop;

    logic                        w_in_acc;
    logic                        w_out_load;
    logic [AW-1:0]               w_head_inc;
    logic [CW:0]                 w_wr_sum;
    logic [AW-1:0]               w_wr_addr;
    logic                        w_wr_en;
    logic                        w_full;
    logic [AW-1:0]               w_rd_addr;
    logic [qsms_pkg::MOVE_W-1:0] w_rd_data;
    logic                        w_rd_kind;
    logic [PW-1:0]               w_rd_pos;
    logic [PW-1:0]               w_lift_next, w_clamp_next;
    logic                        w_push_kind;
    logic [PW-1:0]               w_push_pos;
    logic                        w_push_last;
    logic [PW-1:0]               w_close_m1;
    logic [PW-1:0]               w_mirror;

    function automatic logic [PW-1:0] f_step(input logic [PW-1:0] pos,
                                             input logic [PW-1:0] goal);
        logic [PW-1:0] res;
        if (pos < goal) begin
            res = pos + 1'b1;
        end else if (pos > goal) begin
            res = pos - 1'b1;
        end else begin
            res = pos;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // move queue storage
    // ------------------------------------------------------------------------
    qsms_ram #(
        .P_WIDTH (qsms_pkg::MOVE_W),
        .P_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data ({w_push_kind, w_push_pos}),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_in_ready  = (r_state == qsms_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == qsms_pkg::ST_RESULT) && (!r_out_valid || i_out_ready);

    assign w_head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_wr_sum   = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign w_wr_addr  = (w_wr_sum >= (CW+1)'(QUEUE_DEPTH))
                      ? AW'(w_wr_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(w_wr_sum);
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));

    // second read of a tick looks past the lift move just retired
    assign w_rd_addr  = (r_state == qsms_pkg::ST_LIFT) ? w_head_inc : r_head;
    assign w_rd_kind  = w_rd_data[PW];
    assign w_rd_pos   = w_rd_data[PW-1:0];

    assign w_lift_next  = f_step(r_lift, w_rd_pos);
    assign w_clamp_next = f_step(r_clamp, w_rd_pos);

    assign w_close_m1 = (r_clamp_close != '0) ? r_clamp_close - 1'b1 : '0;
    assign w_mirror   = (r_clamp <= qsms_pkg::MIRROR_SUM) ? qsms_pkg::MIRROR_SUM - r_clamp : '0;

    // move to queue on the current push step
    always_comb begin
        w_push_kind = qsms_pkg::KIND_LIFT;
        w_push_pos  = r_lift_down;
        w_push_last = 1'b1;
        case (r_cmd)
            qsms_pkg::CMD_QUEUE_LIFT: begin
                w_push_pos = r_target;
            end
            qsms_pkg::CMD_QUEUE_CLAMP: begin
                w_push_kind = qsms_pkg::KIND_CLAMP;
                w_push_pos  = r_target;
            end
            qsms_pkg::CMD_LOAD, qsms_pkg::CMD_UNLOAD: begin
                case (r_step)
                    2'd0: begin
                        w_push_last = 1'b0;
                    end
                    2'd1: begin
                        w_push_kind = qsms_pkg::KIND_CLAMP;
                        w_push_pos  = (r_cmd == qsms_pkg::CMD_LOAD) ? r_clamp_close
                                                                    : r_clamp_open;
                        w_push_last = 1'b0;
                    end
                    default: begin
                        w_push_pos = r_lift_up;
                    end
                endcase
            end
            qsms_pkg::CMD_STACK: begin
                case (r_step)
                    2'd0: begin
                        w_push_last = 1'b0;
                    end
                    2'd1: begin
                        w_push_kind = qsms_pkg::KIND_CLAMP;
                        w_push_pos  = w_close_m1;
                        w_push_last = 1'b0;
                    end
                    2'd2: begin
                        w_push_kind = qsms_pkg::KIND_CLAMP;
                        w_push_pos  = r_clamp_close;
                        w_push_last = 1'b0;
                    end
                    default: begin
                        w_push_pos = r_lift_up;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            qsms_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == qsms_pkg::CMD_TICK) begin
                        n_state = (r_paused || r_count == '0) ? qsms_pkg::ST_RESULT
                                                              : qsms_pkg::ST_LIFT;
                    end else if (i_command inside {qsms_pkg::CMD_QUEUE_LIFT,
                                                   qsms_pkg::CMD_QUEUE_CLAMP,
                                                   qsms_pkg::CMD_LOAD,
                                                   qsms_pkg::CMD_UNLOAD,
                                                   qsms_pkg::CMD_STACK}) begin
                        n_state = qsms_pkg::ST_PUSH;
                    end else begin
                        n_state = qsms_pkg::ST_RESULT;
                    end
                end
            end
            qsms_pkg::ST_LIFT: begin
                if (w_rd_kind == qsms_pkg::KIND_LIFT && w_lift_next == w_rd_pos
                    && r_count != CW'(1)) begin
                    n_state = qsms_pkg::ST_CLAMP;
                end else begin
                    n_state = qsms_pkg::ST_RESULT;
                end
            end
            qsms_pkg::ST_CLAMP: begin
                n_state = qsms_pkg::ST_RESULT;
            end
            qsms_pkg::ST_PUSH: begin
                if (w_push_last) begin
                    n_state = qsms_pkg::ST_RESULT;
                end
            end
            qsms_pkg::ST_RESULT: begin
                if (w_out_load) begin
                    n_state = qsms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qsms_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath next values and queue writes
    // ------------------------------------------------------------------------
    always_comb begin
        n_cmd    = r_cmd;
        n_target = r_target;
        n_step   = r_step;
        n_head   = r_head;
        n_count  = r_count;
        n_lift   = r_lift;
        n_clamp  = r_clamp;
        n_paused = r_paused;
        n_drop   = r_drop;
        w_wr_en  = 1'b0;
        case (r_state)
            qsms_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_cmd    = i_command;
                    n_target = i_target;
                    n_step   = '0;
                    n_drop   = 1'b0;
                    case (i_command)
                        qsms_pkg::CMD_PAUSE:   n_paused = 1'b1;
                        qsms_pkg::CMD_UNPAUSE: n_paused = 1'b0;
                        qsms_pkg::CMD_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                        end
                        qsms_pkg::CMD_HOME: begin
                            n_lift  = r_lift_down;
                            n_clamp = r_clamp_close;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            qsms_pkg::ST_LIFT: begin
                if (w_rd_kind == qsms_pkg::KIND_LIFT) begin
                    n_lift = w_lift_next;
                    if (w_lift_next == w_rd_pos) begin
                        n_head  = w_head_inc;
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    // clamp move already at the head
                    n_clamp = w_clamp_next;
                    if (w_clamp_next == w_rd_pos) begin
                        n_head  = w_head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            qsms_pkg::ST_CLAMP: begin
                if (w_rd_kind == qsms_pkg::KIND_CLAMP) begin
                    n_clamp = w_clamp_next;
                    if (w_clamp_next == w_rd_pos) begin
                        n_head  = w_head_inc;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            qsms_pkg::ST_PUSH: begin
                n_step = r_step + 1'b1;
                if (w_full) begin
                    n_drop = 1'b1;
                end else begin
                    w_wr_en = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= qsms_pkg::ST_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_lift   <= '0;
            r_clamp  <= '0;
            r_paused <= 1'b0;
            r_drop   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_lift   <= n_lift;
            r_clamp  <= n_clamp;
            r_paused <= n_paused;
            r_drop   <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_target <= n_target;
        r_step   <= n_step;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lift_down   <= qsms_pkg::RST_LIFT_DOWN;
            r_lift_up     <= qsms_pkg::RST_LIFT_UP;
            r_clamp_open  <= qsms_pkg::RST_CLAMP_OPEN;
            r_clamp_close <= qsms_pkg::RST_CLAMP_CLOSE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                qsms_pkg::REG_LIFT_DOWN:   r_lift_down   <= i_cfg_data;
                qsms_pkg::REG_LIFT_UP:     r_lift_up     <= i_cfg_data;
                qsms_pkg::REG_CLAMP_OPEN:  r_clamp_open  <= i_cfg_data;
                qsms_pkg::REG_CLAMP_CLOSE: r_clamp_close <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_lift   <= r_lift;
            r_out_clamp  <= r_clamp;
            r_out_mirror <= w_mirror;
            r_out_busy   <= (r_count != '0);
            r_out_drop   <= r_drop;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_lift_position         = r_out_lift;
    assign o_clamp_position        = r_out_clamp;
    assign o_clamp_mirror_position = r_out_mirror;
    assign o_busy_res              = r_out_busy;
    assign o_dropped               = r_out_drop;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH) && r_head <= AW'(QUEUE_DEPTH - 1))
        else $error("queue count or head out of range");

    a_paused_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_command == qsms_pkg::CMD_TICK && r_paused)
        |=> ($stable(r_count) && $stable(r_head) && r_state == qsms_pkg::ST_RESULT))
        else $error("paused tick disturbed the queue");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_command == qsms_pkg::CMD_CLEAR) |=> (r_count == '0))
        else $error("clear left moves queued");

    a_drop_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qsms_pkg::ST_RESULT && r_drop)
        |-> (r_cmd == qsms_pkg::CMD_QUEUE_LIFT || r_cmd == qsms_pkg::CMD_QUEUE_CLAMP
             || r_cmd == qsms_pkg::CMD_LOAD || r_cmd == qsms_pkg::CMD_UNLOAD
             || r_cmd == qsms_pkg::CMD_STACK))
        else $error("drop flagged on a command that queues nothing");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (!w_full && r_state == qsms_pkg::ST_PUSH))
        else $error("queue written while full");

endmodule

`default_nettype wire
